FILE: design/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared types and constants for the keyword substitution cipher block.
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int unsigned LETTER_COUNT = 26;
  localparam int unsigned IDX_W        = 5;
  localparam logic [7:0]  UPPER_BASE   = 8'h41;
  localparam logic [7:0]  LOWER_BASE   = 8'h61;
  localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTER_COUNT - 1);
  localparam logic [IDX_W-1:0] FULL_COUNT  = IDX_W'(LETTER_COUNT);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_SEAL  = 2'd2,
    OP_TEXT  = 2'd3
  } opcode_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic key;
    logic seal_start;
    logic seal_step;
    logic text;
  } ksc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic seal_last;
    logic out_stall;
  } ksc_status_t;

  typedef struct packed {
    logic             is_letter;
    logic             lower;
    logic [IDX_W-1:0] idx;
  } letter_t;

  // classify an ascii byte and give its letter index
  function automatic letter_t letter_decode(input logic [7:0] b);
    letter_t     res;
    logic [7:0]  up_off;
    logic [7:0]  lo_off;
    up_off = b - UPPER_BASE;
    lo_off = b - LOWER_BASE;
    res.is_letter = 1'b0;
    res.lower     = 1'b0;
    res.idx       = '0;
    if (b >= UPPER_BASE && up_off < 8'(LETTER_COUNT)) begin
      res.is_letter = 1'b1;
      res.idx       = up_off[IDX_W-1:0];
    end else if (b >= LOWER_BASE && lo_off < 8'(LETTER_COUNT)) begin
      res.is_letter = 1'b1;
      res.lower     = 1'b1;
      res.idx       = lo_off[IDX_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: design/ksc_ctrl.sv
// ----------------------------------------------------------------------------
// ksc_ctrl
// Controller: accepts requests and sequences the table seal.
// ----------------------------------------------------------------------------
module ksc_ctrl import ksc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  opcode_t     in_op,
  input  ksc_status_t status,
  output ksc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // ready while idle and the result register can take a new value
  assign in_ready = (state_r == ST_IDLE) && !status.out_stall;
  assign accept   = in_valid && in_ready;

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.clear      = accept && (in_op == OP_CLEAR);
    cmd.key        = accept && (in_op == OP_KEY);
    cmd.seal_start = accept && (in_op == OP_SEAL);
    cmd.text       = accept && (in_op == OP_TEXT);
    cmd.seal_step  = (state_r == ST_SEAL);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.seal_start) state_nxt = ST_SEAL;
      end
      ST_SEAL: begin
        if (status.seal_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/ksc_dpath.sv
// ----------------------------------------------------------------------------
// ksc_dpath
// Datapath: alphabet tables, used-letter mask, fill count and result register.
// ----------------------------------------------------------------------------
module ksc_dpath import ksc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ksc_cmd_t    cmd,
  output ksc_status_t status,
  input  logic [7:0]  in_byte,
  input  logic        decrypt_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte
);

  logic [IDX_W-1:0] fwd_r [LETTER_COUNT];
  logic [IDX_W-1:0] inv_r [LETTER_COUNT];
  logic [LETTER_COUNT-1:0] used_r, used_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] seal_idx_r, seal_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;

  letter_t          lt;
  logic             app_en;
  logic [IDX_W-1:0] app_letter;
  logic             have;
  logic [IDX_W-1:0] mapped;
  logic [7:0]       result;

  assign lt = letter_decode(in_byte);

  // shared append port: keyword letter or seal sweep letter
  always_comb begin
    app_en     = 1'b0;
    app_letter = seal_idx_r;
    if (cmd.key) begin
      app_letter = lt.idx;
      app_en     = lt.is_letter && !used_r[lt.idx] && (fill_r < FULL_COUNT);
    end else if (cmd.seal_step) begin
      app_en     = !used_r[seal_idx_r] && (fill_r < FULL_COUNT);
    end
  end

  // key state update
  always_comb begin
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    seal_idx_nxt = seal_idx_r;
    if (cmd.clear) begin
      used_nxt = '0;
      fill_nxt = '0;
    end else if (app_en) begin
      used_nxt[app_letter] = 1'b1;
      fill_nxt             = fill_r + IDX_W'(1);
    end
    if (cmd.seal_start) begin
      seal_idx_nxt = LAST_LETTER;
    end else if (cmd.seal_step) begin
      seal_idx_nxt = seal_idx_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      fill_r     <= '0;
      seal_idx_r <= '0;
    end else begin
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      seal_idx_r <= seal_idx_nxt;
    end
  end

  // table writes, contents undefined until written
  always_ff @(posedge clk) begin
    if (app_en) begin
      fwd_r[fill_r]     <= app_letter;
      inv_r[app_letter] <= fill_r;
    end
  end

  // text lookup
  always_comb begin
    have   = 1'b0;
    mapped = '0;
    if (lt.is_letter) begin
      if (decrypt_mode) begin
        have   = used_r[lt.idx];
        mapped = inv_r[lt.idx];
      end else begin
        have   = (lt.idx < fill_r);
        mapped = fwd_r[lt.idx];
      end
    end
    if (have) begin
      result = {3'b000, mapped} + (lt.lower ? LOWER_BASE : UPPER_BASE);
    end else begin
      result = in_byte;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.text) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text) out_byte_r <= result;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign status.out_stall = out_valid_r && !out_ready;
  assign status.seal_last = (seal_idx_r == '0);

endmodule

FILE: design/keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword substitution cipher: builds an alphabet from keyword bytes, seals
// it, then enciphers or deciphers text bytes.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_ready       in_opcode, in_byte_in
//   out_      output     out_valid / out_ready     out_byte_out
//   cfg_      apb        psel, penable, pwrite     paddr, pwdata, prdata
//
// clear and keyword requests update the key state when accepted; a text request does one table lookup.
// a seal request sweeps the letters from last to first: the sequencer visits one letter a cycle.
// rst_n clears the key state, the mode register and the result valid flag;
// the alphabet tables are not cleared and count as unfilled.
// in_ready drops during a seal and while a held result is not taken.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher import ksc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ksc_cmd_t    cmd;
  ksc_status_t status;
  logic        decrypt_mode_r;
  logic        cfg_sel0;

  // configuration register
  assign pready   = 1'b1;
  assign cfg_sel0 = (paddr[2] == 1'b0);
  assign prdata   = cfg_sel0 ? {31'b0, decrypt_mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && cfg_sel0) begin
      decrypt_mode_r <= pwdata[0];
    end
  end

  ksc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (opcode_t'(in_opcode)),
    .status   (status),
    .cmd      (cmd)
  );

  ksc_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_byte      (in_byte_in),
    .decrypt_mode (decrypt_mode_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte_out)
  );

endmodule
